// File: sv/qpht_pkg.sv
// Package: shared types, codes and sizes for the quadratic-probe hash table.
`default_nettype none

package qpht_pkg;

  localparam int CAPACITY = 1024;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int SIZE_W   = 11;
  localparam int KEY_W    = 31;
  localparam int UNIT_W   = SIZE_W + 1;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_SEARCH = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_DEAD  = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_LIMIT     = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_FOUND     = 3'd5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1021;

  typedef struct packed {
    logic [1:0]       action;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] live_count;
  } out_t;

endpackage

`default_nettype wire

// File: sv/qpht_modu.sv
// Shared modular reduction step: one conditional subtract of the modulus.
`default_nettype none

module qpht_modu (
  input  wire logic [qpht_pkg::UNIT_W-1:0] x,
  input  wire logic [qpht_pkg::SIZE_W-1:0] m,
  output logic      [qpht_pkg::UNIT_W-1:0] y
);

  logic [qpht_pkg::UNIT_W-1:0] m_ext;

  assign m_ext = {1'b0, m};
  assign y     = (x >= m_ext) ? (x - m_ext) : x;

endmodule

`default_nettype wire

// File: sv/quadratic_probe_hash_table.sv
// Top level: quadratic-probe open-addressing key set with sequencer and slot store.
//
// Input channel (in_valid / in_stall / in_data): one beat carries an action
// (insert, remove, search) and a 31-bit key. in_stall is high whenever the
// sequencer is busy, so one operation is in flight at a time.
// Result channel (out_valid / out_stall / out_data): one beat per input beat
// with status, slot and live key count. The result sits in an output register;
// while the receiver stalls it holds and the sequencer waits in its final state.
// Config channel (cfg_valid / cfg_ready / cfg_data): table_size, always ready.
// Write it only while no operation is in flight.
// Operation: the home slot is key mod size, found by a restoring remainder over
// the 31 key bits in the shared subtract unit. Each probe then costs a read
// (S_RD) and a check (S_CHK), plus S_ADV1 and S_ADV2 in the same unit to step
// to the next slot (home + i*i, done incrementally with odd steps). A result
// is loaded from S_FIN; the unused action code goes there straight from idle.
// The input opens again at the edge that loads the result, so the rate of
// operations depends on the probe chain length.
// Reset: synchronous, active low. Afterwards a clearing pass marks all 1024
// slots empty, one per cycle, with in_stall held high.
`default_nettype none

module quadratic_probe_hash_table (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire qpht_pkg::in_t              in_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output qpht_pkg::out_t                  out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [qpht_pkg::SIZE_W-1:0] cfg_data
);

  localparam int SW = qpht_pkg::SLOT_W;
  localparam int ZW = qpht_pkg::SIZE_W;
  localparam int KW = qpht_pkg::KEY_W;
  localparam int UW = qpht_pkg::UNIT_W;
  localparam int MW = KW + 2;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_RD, S_CHK, S_ADV1, S_ADV2, S_FIN
  } state_t;

  state_t            state_r;
  logic [ZW-1:0]     size_r;      // raw register value
  logic [ZW-1:0]     m_r;         // clamped modulus for this operation
  logic [SW-1:0]     last_r;      // final probe index, m/2
  logic [1:0]        action_r;
  logic [KW-1:0]     key_r;
  logic [4:0]        bit_r;
  logic [SW-1:0]     rem_r;
  logic [SW-1:0]     s_r;         // current probe slot
  logic [SW-1:0]     i_r;         // probe number
  logic [ZW-1:0]     step_r;      // 2i+1
  logic [UW-1:0]     sum_r;
  logic [ZW-1:0]     count_r;
  logic [SW-1:0]     clr_r;
  logic [2:0]        status_r;
  logic [SW-1:0]     slot_r;
  logic              out_valid_r;
  qpht_pkg::out_t    out_data_r;

  // slot store: {mark, key}
  logic [MW-1:0]     mem [qpht_pkg::CAPACITY];
  logic [MW-1:0]     rdata_r;
  logic              mem_we;
  logic [SW-1:0]     mem_addr;
  logic [MW-1:0]     mem_wdata;

  logic [UW-1:0]     unit_x;
  logic [UW-1:0]     unit_y;
  logic [ZW-1:0]     m_in;
  logic [1:0]        rd_mark;
  logic [KW-1:0]     rd_key;
  logic              key_hit;
  logic              in_beat;
  logic              out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_beat   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // zero acts as one, oversize acts as full capacity
  always_comb begin
    if (size_r == '0) begin
      m_in = ZW'(1);
    end else if (size_r > ZW'(qpht_pkg::CAPACITY)) begin
      m_in = ZW'(qpht_pkg::CAPACITY);
    end else begin
      m_in = size_r;
    end
  end

  assign rd_mark = rdata_r[MW-1:KW];
  assign rd_key  = rdata_r[KW-1:0];
  assign key_hit = (rd_key == key_r);

  // shared unit: remainder steps while dividing, then slot wrap-around
  assign unit_x = (state_r == S_DIV) ? {1'b0, rem_r, key_r[bit_r]} : sum_r;

  qpht_modu u_modu (
    .x (unit_x),
    .m (m_r),
    .y (unit_y)
  );

  // store port
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = s_r;
    mem_wdata = {qpht_pkg::MARK_LIVE, key_r};
    case (state_r)
      S_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = {qpht_pkg::MARK_EMPTY, {KW{1'b0}}};
      end
      S_CHK: begin
        if (action_r == qpht_pkg::ACT_INSERT) begin
          mem_we = (rd_mark != qpht_pkg::MARK_LIVE);
        end else if (action_r == qpht_pkg::ACT_REMOVE) begin
          mem_we    = (rd_mark == qpht_pkg::MARK_LIVE) && key_hit;
          mem_wdata = {qpht_pkg::MARK_DEAD, key_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    rdata_r <= mem[mem_addr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      size_r      <= qpht_pkg::SIZE_RESET;
      count_r     <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        size_r <= cfg_data;
      end
      // taken result beat drops; in S_FIN the register is reloaded below instead
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + SW'(1);
          if (clr_r == SW'(qpht_pkg::CAPACITY - 1)) begin
            state_r <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_beat) begin
            action_r <= in_data.action;
            key_r    <= in_data.key;
            m_r      <= m_in;
            last_r   <= m_in[ZW-1:1];
            rem_r    <= '0;
            bit_r    <= 5'(KW - 1);
            status_r <= qpht_pkg::ST_NOTFOUND;
            slot_r   <= '0;
            if (in_data.action == qpht_pkg::ACT_INSERT ||
                in_data.action == qpht_pkg::ACT_REMOVE ||
                in_data.action == qpht_pkg::ACT_SEARCH) begin
              state_r <= S_DIV;
            end else begin
              state_r <= S_FIN;
            end
          end
        end

        S_DIV: begin
          rem_r <= unit_y[SW-1:0];
          bit_r <= bit_r - 5'd1;
          if (bit_r == '0) begin
            s_r     <= unit_y[SW-1:0];
            i_r     <= '0;
            step_r  <= ZW'(1);
            state_r <= S_RD;
          end
        end

        S_RD: begin
          state_r <= S_CHK;
        end

        S_CHK: begin
          sum_r   <= {2'b00, s_r} + {1'b0, step_r};
          state_r <= S_ADV1;
          if (action_r == qpht_pkg::ACT_INSERT) begin
            if (rd_mark != qpht_pkg::MARK_LIVE) begin
              status_r <= qpht_pkg::ST_INSERTED;
              slot_r   <= s_r;
              count_r  <= count_r + ZW'(1);
              state_r  <= S_FIN;
            end else if (key_hit) begin
              status_r <= qpht_pkg::ST_DUPLICATE;
              slot_r   <= s_r;
              state_r  <= S_FIN;
            end else if (i_r == last_r) begin
              status_r <= qpht_pkg::ST_LIMIT;
              state_r  <= S_FIN;
            end
          end else begin
            if (rd_mark == qpht_pkg::MARK_EMPTY) begin
              state_r <= S_FIN;
            end else if (rd_mark == qpht_pkg::MARK_LIVE && key_hit) begin
              slot_r  <= s_r;
              state_r <= S_FIN;
              if (action_r == qpht_pkg::ACT_REMOVE) begin
                status_r <= qpht_pkg::ST_REMOVED;
                if (count_r != '0) begin
                  count_r <= count_r - ZW'(1);
                end
              end else begin
                status_r <= qpht_pkg::ST_FOUND;
              end
            end else if (i_r == last_r) begin
              state_r <= S_FIN;
            end
          end
        end

        S_ADV1: begin
          sum_r   <= unit_y;
          state_r <= S_ADV2;
        end

        S_ADV2: begin
          s_r     <= unit_y[SW-1:0];
          i_r     <= i_r + SW'(1);
          step_r  <= step_r + ZW'(2);
          state_r <= S_RD;
        end

        S_FIN: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_data_r.status     <= status_r;
            out_data_r.slot       <= slot_r;
            out_data_r.live_count <= count_r;
            state_r               <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/qpht_chk.sv
// Port-level checker for the hash table, bound to the top level.
`default_nettype none

module qpht_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire qpht_pkg::out_t              out_data
);

  // one operation in flight: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an operation is in flight");

  // no result can appear the cycle after an accept
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result rose straight after an accept");

  // status codes stay within the defined set
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= qpht_pkg::ST_FOUND)
    else $error("undefined status code");

  // misses report slot zero
  a_miss_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == qpht_pkg::ST_LIMIT ||
                  out_data.status == qpht_pkg::ST_NOTFOUND)
    |-> out_data.slot == '0)
    else $error("miss reported a non-zero slot");

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

endmodule

bind quadratic_probe_hash_table qpht_chk u_qpht_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
